@@ sv/fsl_pkg.sv @@
// package: types, codes, constants and helpers for the slope limiter
`default_nettype none
package fsl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_CELLS     = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [2:0]  MODE_RESET = 3'd2;
  localparam logic [15:0] EPS_RESET  = 16'd655;

  typedef enum logic [2:0] {
    MODE_FIRST    = 3'd0,
    MODE_UNLIM    = 3'd1,
    MODE_VANLEER  = 3'd2,
    MODE_SUPERBEE = 3'd3,
    MODE_MC       = 3'd4,
    MODE_KOREN    = 3'd5,
    MODE_THIRD    = 3'd6,
    MODE_INVALID  = 3'd7
  } fsl_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_EPS  = 2'd1
  } fsl_cfg_idx_e;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] den;
    logic        inv;
    logic        use_div;
    logic [31:0] base;
    logic        bad;
  } fsl_cell_t;

  function automatic logic signed [33:0] fsl_min(logic signed [33:0] a, logic signed [33:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [33:0] fsl_max(logic signed [33:0] a, logic signed [33:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [31:0] fsl_sat(logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/fsl_if.sv @@
// stream and configuration interfaces of the slope limiter
`default_nettype none
interface fsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slope_ratio;
  logic signed [31:0] smoothness;
  modport source (output valid, output slope_ratio, output smoothness, input ready);
  modport sink (input valid, input slope_ratio, input smoothness, output ready);
endinterface

interface fsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] limiter_value;
  logic               bad_mode;
  modport source (output valid, output limiter_value, output bad_mode, input ready);
  modport sink (input valid, input limiter_value, input bad_mode, output ready);
endinterface

interface fsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/flux_slope_limiter.sv @@
// top level of the tvd slope limiter
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    slope_ratio, smoothness
//  out_o    out  valid/ready    limiter_value, bad_mode
//  cfg_i    in   valid/ready    index, data (0 limiter_mode, 1 blend_width)
//
// one item per cycle while out_o is ready; four front stages and a chain
// of 32 divider cells, one quotient bit per cell
// every stage holds when the one after it is full and stalled
// reset empties all stages and sets mode 2 and blend width 655
`default_nettype none
module flux_slope_limiter import fsl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fsl_in_if.sink    in_i,
  fsl_out_if.source out_o,
  fsl_cfg_if.sink   cfg_i
);

  fsl_mode_e   mode_q;
  logic [15:0] eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fsl_mode_e'(MODE_RESET);
      eps_q  <= EPS_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE: mode_q <= fsl_mode_e'(cfg_i.data[2:0]);
        CFG_EPS:  eps_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  fsl_cell_t data [0:DIV_CELLS];
  logic      vld  [0:DIV_CELLS];
  logic      rdy  [0:DIV_CELLS];

  fsl_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .eps_i       (eps_q),
    .in_i        (in_i),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .out_data_o  (data[0])
  );

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    fsl_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_data_i   (data[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_data_o  (data[k+1])
    );
  end

  assign rdy[DIV_CELLS] = out_o.ready;
  assign out_o.valid    = vld[DIV_CELLS];
  assign out_o.bad_mode = data[DIV_CELLS].bad;

  always_comb begin
    if (data[DIV_CELLS].use_div) begin
      out_o.limiter_value = signed'(data[DIV_CELLS].inv ? ~data[DIV_CELLS].lo
                                                        : data[DIV_CELLS].lo);
    end else begin
      out_o.limiter_value = signed'(data[DIV_CELLS].base);
    end
  end

endmodule
`default_nettype wire

@@ sv/fsl_prep.sv @@
// front stages: divide by three, limiter selection, blend products
`default_nettype none
module fsl_prep import fsl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fsl_mode_e  mode_i,
  input  wire logic [15:0] eps_i,
  fsl_in_if.sink          in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output fsl_cell_t       out_data_o
);

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] TWO = 34'sd2 <<< FRAC_BITS;
  localparam logic [63:0] ONE_SIX_W = ((64'd16 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic signed [33:0] ONE_SIX = signed'(ONE_SIX_W[33:0]);
  localparam logic [34:0] DIV3_OFS = 35'd3 << 32;
  localparam logic [34:0] DIV3_ADJ = 35'd1 << 32;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: split divide by three into two small products
  logic signed [33:0] x1;
  logic [34:0] u1;
  logic [16:0] uh1;
  logic [18:0] s1;
  logic [33:0] p1_d, p1_q;
  logic [38:0] p2_d, p2_q;
  logic signed [31:0] r1_q, eta1_q;

  always_comb begin
    if (mode_i == MODE_KOREN) begin
      x1 = ONE + (34'(in_i.slope_ratio) <<< 1);
    end else begin
      x1 = TWO + 34'(in_i.slope_ratio);
    end
    u1   = 35'(x1) + DIV3_OFS;
    uh1  = u1[34:18];
    s1   = 19'(uh1) + 19'(u1[17:0]);
    p1_d = 34'(uh1) * 34'd87381;
    p2_d = 39'(s1) * 39'd699051;
  end

  // stage 2: finish divide by three
  logic [34:0] q3_sum;
  logic signed [33:0] t_d, t_q;
  logic signed [31:0] r2_q, eta2_q;

  always_comb begin
    q3_sum = 35'(p1_q) + 35'(p2_q[38:21]) - DIV3_ADJ;
    t_d    = signed'(q3_sum[33:0]);
  end

  // stage 3: limiter formulas
  logic signed [33:0] r, r2x, eta, eps, a, hh, h, e, w1w, w2w, base;
  logic use_div_d, blend_d, bad_d;
  logic [31:0] base3_q;
  logic use_div3_q, blend3_q, bad3_q;
  logic [17:0] w1_q, w2_q;
  logic signed [31:0] t3_q, h3_q;
  logic [63:0] vnum_d, vnum3_q;
  logic [31:0] vden_d, vden3_q;
  logic [33:0] vden_w;

  always_comb begin
    r    = 34'(r2_q);
    r2x  = r <<< 1;
    eta  = 34'(eta2_q);
    eps  = signed'({18'b0, eps_i});
    a    = fsl_min(fsl_min(r2x, t_q), ONE_SIX);
    hh   = fsl_max((-r) >>> 1, a);
    h    = fsl_max(34'sd0, fsl_min(t_q, hh));
    e    = eta - ONE;
    w1w  = eps - e;
    w2w  = eps + e;
    vnum_d = {33'b0, r2_q[30:0]} << (FRAC_BITS + 1);
    vden_w = unsigned'(ONE + r);
    vden_d = vden_w[31:0];
    base = 34'sd0;
    use_div_d = 1'b0;
    blend_d   = 1'b0;
    bad_d     = 1'b0;
    case (mode_i)
      MODE_FIRST:    base = 34'sd0;
      MODE_UNLIM:    base = r;
      MODE_VANLEER:  use_div_d = (r > 34'sd0);
      MODE_SUPERBEE: base = fsl_max(34'sd0, fsl_max(fsl_min(r2x, ONE), fsl_min(r, TWO)));
      MODE_MC:       base = fsl_max(34'sd0, fsl_min(fsl_min(r2x, (ONE + r) >>> 1), TWO));
      MODE_KOREN:    base = fsl_max(34'sd0, fsl_min(r2x, fsl_min(t_q, TWO)));
      MODE_THIRD: begin
        if (eta <= ONE - eps) begin
          base = t_q;
        end else if (eta >= ONE + eps) begin
          base = h;
        end else begin
          use_div_d = 1'b1;
          blend_d   = 1'b1;
        end
      end
      default:       bad_d = 1'b1;
    endcase
  end

  // stage 4: blend products
  logic signed [18:0] w1s, w2s;
  logic signed [50:0] m1_d, m2_d, m1_q, m2_q;
  logic [31:0] base4_q;
  logic use_div4_q, blend4_q, bad4_q;
  logic [63:0] vnum4_q;
  logic [31:0] vden4_q;

  always_comb begin
    w1s  = signed'({1'b0, w1_q});
    w2s  = signed'({1'b0, w2_q});
    m1_d = 51'(w1s) * 51'(t3_q);
    m2_d = 51'(w2s) * 51'(h3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      r1_q   <= in_i.slope_ratio;
      eta1_q <= in_i.smoothness;
    end
    if (en2) begin
      t_q    <= t_d;
      r2_q   <= r1_q;
      eta2_q <= eta1_q;
    end
    if (en3) begin
      base3_q    <= fsl_sat(base);
      use_div3_q <= use_div_d;
      blend3_q   <= blend_d;
      bad3_q     <= bad_d;
      w1_q       <= w1w[17:0];
      w2_q       <= w2w[17:0];
      t3_q       <= t_q[31:0];
      h3_q       <= h[31:0];
      vnum3_q    <= vnum_d;
      vden3_q    <= vden_d;
    end
    if (en4) begin
      m1_q       <= m1_d;
      m2_q       <= m2_d;
      base4_q    <= base3_q;
      use_div4_q <= use_div3_q;
      blend4_q   <= blend3_q;
      bad4_q     <= bad3_q;
      vnum4_q    <= vnum3_q;
      vden4_q    <= vden3_q;
    end
  end

  // numerator for the divider chain, negative blend sums as ones complement
  logic signed [50:0] n;
  logic [50:0] mag;
  logic [63:0] num;

  always_comb begin
    n   = m1_q + m2_q;
    mag = n[50] ? ~unsigned'(n) : unsigned'(n);
    num = blend4_q ? {14'b0, mag[49:0]} : vnum4_q;
    out_data_o.rem     = num[63:32];
    out_data_o.lo      = num[31:0];
    out_data_o.den     = blend4_q ? {15'b0, eps_i, 1'b0} : vden4_q;
    out_data_o.inv     = blend4_q & n[50];
    out_data_o.use_div = use_div4_q;
    out_data_o.base    = base4_q;
    out_data_o.bad     = bad4_q;
  end

endmodule
`default_nettype wire

@@ sv/fsl_div_cell.sv @@
// one restoring divider cell: one quotient bit per cell
`default_nettype none
module fsl_div_cell import fsl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fsl_cell_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output fsl_cell_t      out_data_o
);

  logic      v_q;
  fsl_cell_t d_d, d_q;
  logic [32:0] rs, diff;
  logic        ge;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

  always_comb begin
    rs   = {in_data_i.rem, in_data_i.lo[31]};
    diff = rs - {1'b0, in_data_i.den};
    ge   = (rs >= {1'b0, in_data_i.den});
    d_d     = in_data_i;
    d_d.rem = ge ? diff[31:0] : rs[31:0];
    d_d.lo  = {in_data_i.lo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) d_q <= d_d;
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the tvd slope limiter: directed table, then random phases
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import fsl_pkg::*;

  localparam longint FX_ONE     = 64'sd65536;
  localparam longint FX_TWO     = 64'sd131072;
  localparam longint FX_ONE_SIX = 64'sd104858;
  localparam int     DRAIN_CYC  = 40;
  localparam int     IDLE_LIMIT = 5000;
  localparam int     RAND_ITEMS = 1620;
  localparam int     PHASE_LEN  = 90;

  typedef struct {
    fsl_mode_e   mode;
    logic [15:0] eps;
    logic [31:0] r;
    logic [31:0] eta;
    bit          typed;
    logic [31:0] phi;
    logic        bad;
  } stim_row_t;

  typedef struct {
    logic [31:0] phi;
    logic        bad;
  } limiter_res_t;

  logic clk_i;
  logic rst_ni;

  fsl_in_if  in_bus ();
  fsl_out_if out_bus ();
  fsl_cfg_if cfg_bus ();

  flux_slope_limiter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  limiter_res_t pending_q[$];
  fsl_mode_e    cur_mode;
  logic [15:0]  cur_eps;
  int           err_cnt;
  int           idle_cycles;
  int           stall_pct;
  bit           holdoff_req;
  int           holdoff_left;
  int           burst_left;
  int           sent_cnt;
  int           got_cnt;
  int           mode_cnt[8];
  stim_row_t    dir_tab[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) begin
      q--;
    end
    return q;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic limiter_res_t predict_phi(fsl_mode_e mode, logic [15:0] eps_u,
                                               logic [31:0] r_u, logic [31:0] eta_u);
    longint r, eta, eps, phi, t, h, e;
    limiter_res_t res;
    r   = longint'($signed(r_u));
    eta = longint'($signed(eta_u));
    eps = longint'(eps_u);
    phi = 0;
    res.bad = 1'b0;
    case (mode)
      MODE_FIRST:    phi = 0;
      MODE_UNLIM:    phi = r;
      MODE_VANLEER:  phi = (r <= 0) ? 0 : floor_div(2 * r * FX_ONE, FX_ONE + r);
      MODE_SUPERBEE: phi = lmax(0, lmax(lmin(2 * r, FX_ONE), lmin(r, FX_TWO)));
      MODE_MC:       phi = lmax(0, lmin(lmin(2 * r, floor_div(FX_ONE + r, 2)), FX_TWO));
      MODE_KOREN:    phi = lmax(0, lmin(2 * r, lmin(floor_div(FX_ONE + 2 * r, 3), FX_TWO)));
      MODE_THIRD: begin
        t = floor_div(FX_TWO + r, 3);
        h = lmax(floor_div(-r, 2), lmin(lmin(2 * r, t), FX_ONE_SIX));
        h = lmax(0, lmin(t, h));
        if (eta <= FX_ONE - eps) begin
          phi = t;
        end else if (eta >= FX_ONE + eps) begin
          phi = h;
        end else begin
          e = eta - FX_ONE;
          phi = floor_div((eps - e) * t + (eps + e) * h, 2 * eps);
        end
      end
      default: begin
        phi = 0;
        res.bad = 1'b1;
      end
    endcase
    if (phi > 64'sd2147483647) begin
      phi = 64'sd2147483647;
    end else if (phi < -64'sd2147483648) begin
      phi = -64'sd2147483648;
    end
    res.phi = phi[31:0];
    return res;
  endfunction

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      holdoff_left  <= 0;
    end else if (holdoff_req && holdoff_left == 0) begin
      holdoff_left  <= 300;
      out_bus.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left  <= holdoff_left - 1;
      out_bus.ready <= (holdoff_left == 1);
    end else begin
      out_bus.ready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    limiter_res_t exp_res;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got_cnt++;
      if (pending_q.size() == 0) begin
        $error("unexpected item: limiter_value %h bad_mode %b",
               out_bus.limiter_value, out_bus.bad_mode);
        err_cnt++;
      end else begin
        exp_res = pending_q.pop_front();
        if (out_bus.limiter_value !== exp_res.phi) begin
          $error("limiter_value: expected %h actual %h", exp_res.phi, out_bus.limiter_value);
          err_cnt++;
        end
        if (out_bus.bad_mode !== exp_res.bad) begin
          $error("bad_mode: expected %b actual %b", exp_res.bad, out_bus.bad_mode);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d items still pending", pending_q.size());
      $display("flux_slope_limiter test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(fsl_cfg_idx_e idx, logic [15:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_config(fsl_mode_e mode, logic [15:0] eps);
    if (mode != cur_mode) begin
      write_reg(CFG_MODE, 16'(mode));
      cur_mode = mode;
    end
    if (eps != cur_eps) begin
      write_reg(CFG_EPS, eps);
      cur_eps = eps;
    end
  endtask

  task automatic send_item(logic [31:0] r, logic [31:0] eta, bit typed, limiter_res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.slope_ratio <= r;
    in_bus.smoothness  <= eta;
    @(posedge clk_i);
    while (!in_bus.ready) begin
      @(posedge clk_i);
    end
    pending_q.push_back(typed ? typed_res : predict_phi(cur_mode, cur_eps, r, eta));
    sent_cnt++;
    mode_cnt[cur_mode]++;
    @(negedge clk_i);
  endtask

  function automatic stim_row_t mk_row(fsl_mode_e mode, logic [15:0] eps, logic [31:0] r,
                                       logic [31:0] eta, bit typed, logic [31:0] phi,
                                       logic bad);
    stim_row_t row;
    row.mode = mode; row.eps = eps; row.r = r; row.eta = eta;
    row.typed = typed; row.phi = phi; row.bad = bad;
    return row;
  endfunction

  function automatic logic [31:0] rand_ratio();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 32'(int'($urandom_range(10 * 65536)) - 5 * 65536);
      5, 6, 7:       return $urandom;
      8:             return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      default:       return 32'(int'($urandom_range(16)) - 8);
    endcase
  endfunction

  function automatic logic [31:0] rand_eta(logic [15:0] eps);
    int span;
    span = int'(eps) + 16;
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return 32'(65536 + int'($urandom_range(2 * span)) - span);
  endfunction

  initial begin
    limiter_res_t tres;
    stim_row_t    row;
    fsl_mode_e    ph_mode;
    logic [15:0]  ph_eps;
    int           phase;
    int           n;
    err_cnt = 0; idle_cycles = 0; stall_pct = 0; holdoff_req = 0;
    burst_left = 0; sent_cnt = 0; got_cnt = 0;
    foreach (mode_cnt[i]) mode_cnt[i] = 0;
    cur_mode = fsl_mode_e'(MODE_RESET);
    cur_eps  = EPS_RESET;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0; in_bus.slope_ratio = '0; in_bus.smoothness = '0;
    cfg_bus.valid = 1'b0; cfg_bus.index = CFG_MODE; cfg_bus.data = '0;

    // reset values first, then extremes of every mode
    dir_tab.push_back(mk_row(MODE_VANLEER, 16'd655, 32'h00010000, 0, 1, 32'h00010000, 0));
    dir_tab.push_back(mk_row(MODE_VANLEER, 16'd655, 32'h00000000, 0, 1, 32'h0, 0));
    dir_tab.push_back(mk_row(MODE_VANLEER, 16'd655, 32'h80000000, 0, 1, 32'h0, 0));
    dir_tab.push_back(mk_row(MODE_VANLEER, 16'd655, 32'h7fffffff, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_FIRST, 16'd655, 32'h7fffffff, 32'hffffffff, 1, 32'h0, 0));
    dir_tab.push_back(mk_row(MODE_UNLIM, 16'd655, 32'h7fffffff, 0, 1, 32'h7fffffff, 0));
    dir_tab.push_back(mk_row(MODE_UNLIM, 16'd655, 32'h80000000, 0, 1, 32'h80000000, 0));
    dir_tab.push_back(mk_row(MODE_SUPERBEE, 16'd655, 32'h7fffffff, 0, 1, 32'h00020000, 0));
    dir_tab.push_back(mk_row(MODE_SUPERBEE, 16'd655, 32'h80000000, 0, 1, 32'h0, 0));
    dir_tab.push_back(mk_row(MODE_SUPERBEE, 16'd655, 32'h00008000, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_MC, 16'd655, 32'h7fffffff, 0, 1, 32'h00020000, 0));
    dir_tab.push_back(mk_row(MODE_MC, 16'd655, 32'h80000000, 0, 1, 32'h0, 0));
    dir_tab.push_back(mk_row(MODE_KOREN, 16'd655, 32'h7fffffff, 0, 1, 32'h00020000, 0));
    dir_tab.push_back(mk_row(MODE_KOREN, 16'd655, 32'h00018000, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_INVALID, 16'd655, 32'h00010000, 0, 1, 32'h0, 1));
    dir_tab.push_back(mk_row(MODE_INVALID, 16'd655, 32'h80000000, 32'h7fffffff, 1, 32'h0, 1));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd655, 32'h0, 32'h80000000, 1, 32'd43690, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd655, 32'h00020000, 32'h7fffffff, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd655, 32'h00020000, 32'h00010000, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd655, 32'h7fffffff, 32'h00010100, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd0, 32'hfffe0000, 32'h00010000, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd0, 32'h00030000, 32'h00010001, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd65535, 32'h80000000, 32'h00018000, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd65535, 32'h00008000, 32'h00000001, 0, 0, 0));
    dir_tab.push_back(mk_row(MODE_THIRD, 16'd1, 32'h00010000, 32'h00010000, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      set_config(row.mode, row.eps);
      tres.phi = row.phi;
      tres.bad = row.bad;
      send_item(row.r, row.eta, row.typed, tres);
    end

    n = 0;
    phase = 0;
    while (n < RAND_ITEMS) begin
      ph_mode = fsl_mode_e'(phase % 8);
      if (phase % 8 == 0 && phase > 0) begin
        ph_mode = ($urandom_range(2) == 0) ? MODE_THIRD : fsl_mode_e'($urandom_range(7));
      end
      case ($urandom_range(4))
        0:       ph_eps = 16'd0;
        1:       ph_eps = 16'd65535;
        2:       ph_eps = 16'd1;
        default: ph_eps = 16'($urandom_range(1, 65535));
      endcase
      set_config(ph_mode, ph_eps);
      case (phase % 3)
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        default: stall_pct = 70;
      endcase
      if (phase == 3) begin
        holdoff_req = 1'b1;
      end
      repeat (PHASE_LEN) begin
        send_item(rand_ratio(), rand_eta(cur_eps), 0, tres);
        n++;
        if (holdoff_left > 0) begin
          holdoff_req = 1'b0;
        end
      end
      phase++;
    end

    wait_drained();
    $display("sent %0d items, checked %0d results over %0d random phases", sent_cnt, got_cnt,
             phase);
    $display("items per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_cnt[0], mode_cnt[1],
             mode_cnt[2], mode_cnt[3], mode_cnt[4], mode_cnt[5], mode_cnt[6], mode_cnt[7]);
    if (err_cnt == 0) begin
      $display("flux_slope_limiter test passed");
    end else begin
      $display("flux_slope_limiter test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
